// File: design/assert_macros.svh
// Assertion macros used by the RTL top level of the text line decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on clk_i, quiet while rst_ni is low.
`define TLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent check, sampled on clk_i, also active during reset.
`define TLD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/tld_pkg.sv
// Types, constants and helper functions of the text line decoder.
`default_nettype none

package tld_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] CpRepl     = 21'h00FFFD;
  localparam logic [CpW-1:0] CpNewline  = 21'h00000A;
  localparam logic [CpW-1:0] CpSurrBase = 21'h010000;
  localparam logic [15:0]    LeadLo     = 16'hD800;
  localparam logic [15:0]    LeadHi     = 16'hDBFF;
  localparam logic [15:0]    TrailLo    = 16'hDC00;
  localparam logic [15:0]    TrailHi    = 16'hDFFF;

  typedef enum logic [1:0] {
    MODE_LATIN1  = 2'd0,
    MODE_UTF8    = 2'd1,
    MODE_UTF16LE = 2'd2,
    MODE_UTF16BE = 2'd3
  } mode_e;

  typedef struct packed {
    logic [2:0]     phase;
    logic [CpW-1:0] acc;
    logic [2:0]     seq_len;
    logic [15:0]    first_unit;
    logic [7:0]     held_byte;
    logic           line_nonempty;
  } state_t;

  typedef struct packed {
    logic           valid;
    logic [CpW-1:0] code_point;
    logic           char_valid;
    logic           line_end;
  } res_t;

  // Smallest value that a UTF-8 sequence of the given length may carry.
  function automatic logic [CpW-1:0] utf8_min(input logic [2:0] len);
    logic [CpW-1:0] m;
    unique case (len)
      3'd2:    m = 21'h000080;
      3'd3:    m = 21'h000800;
      3'd4:    m = 21'h010000;
      default: m = 21'h000000;
    endcase
    return m;
  endfunction

  function automatic logic [CpW-1:0] sanitize(input logic [CpW-1:0] cp);
    logic [CpW-1:0] r;
    if (cp >= 21'h00D800 && cp <= 21'h00DFFF) begin
      r = CpRepl;
    end else if (cp == 21'h00FFFF || cp == 21'h00FFFE || cp == 21'h00FEFF) begin
      r = CpRepl;
    end else begin
      r = cp;
    end
    return r;
  endfunction

  // A newline becomes a line end; anything else a sanitised character.
  function automatic res_t emit(input logic [CpW-1:0] cp);
    res_t r;
    r.valid = 1'b1;
    if (cp == CpNewline) begin
      r.code_point = '0;
      r.char_valid = 1'b0;
      r.line_end   = 1'b1;
    end else begin
      r.code_point = sanitize(cp);
      r.char_valid = 1'b1;
      r.line_end   = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/tld_decode.sv
// Decode logic of one transaction: next state and result from state and byte.
`default_nettype none

module tld_decode (
  input  var tld_pkg::mode_e  mode_i,
  input  var tld_pkg::state_t st_i,
  input  wire logic           kind_i,
  input  wire logic [7:0]     byte_req_i,
  output tld_pkg::state_t     st_o,
  output tld_pkg::res_t       res_o
);

  logic [20:0] acc_shift;
  logic [2:0]  lead_len;
  logic [15:0] unit;
  logic [20:0] pair_cp;
  logic        little;

  assign acc_shift = {st_i.acc[14:0], byte_req_i[5:0]};
  assign little    = (mode_i == tld_pkg::MODE_UTF16LE);
  assign unit      = little ? {byte_req_i, st_i.held_byte} : {st_i.held_byte, byte_req_i};
  assign pair_cp   = 21'({st_i.first_unit[9:0], unit[9:0]}) + tld_pkg::CpSurrBase;

  always_comb begin
    priority if (!byte_req_i[7]) lead_len = 3'd0;
    else if (!byte_req_i[6])     lead_len = 3'd1;
    else if (!byte_req_i[5])     lead_len = 3'd2;
    else if (!byte_req_i[4])     lead_len = 3'd3;
    else if (!byte_req_i[3])     lead_len = 3'd4;
    else                         lead_len = 3'd5;
  end

  always_comb begin
    tld_pkg::state_t st_drop;
    st_drop               = '0;
    st_drop.line_nonempty = st_i.line_nonempty;
    st_o  = st_i;
    res_o = '0;

    if (kind_i) begin
      // End of stream: drop the partial sequence, close a non-empty line.
      st_o               = st_drop;
      st_o.line_nonempty = 1'b0;
      if (st_i.line_nonempty) begin
        res_o.valid    = 1'b1;
        res_o.line_end = 1'b1;
      end
    end else begin
      unique case (mode_i)
        tld_pkg::MODE_UTF8: begin
          if (st_i.phase != 3'd0) begin
            if (byte_req_i[7:6] != 2'b10) begin
              st_o  = st_drop;
              res_o = tld_pkg::emit(tld_pkg::CpRepl);
            end else if (st_i.phase == 3'd1) begin
              st_o = st_drop;
              if (st_i.seq_len > 3'd4 || acc_shift < tld_pkg::utf8_min(st_i.seq_len)) begin
                res_o = tld_pkg::emit(tld_pkg::CpRepl);
              end else begin
                res_o = tld_pkg::emit(acc_shift);
              end
            end else begin
              st_o.acc   = acc_shift;
              st_o.phase = st_i.phase - 3'd1;
            end
          end else begin
            unique case (lead_len)
              3'd0: res_o = tld_pkg::emit(21'(byte_req_i));
              3'd2: begin
                st_o.acc     = 21'(byte_req_i[4:0]);
                st_o.seq_len = lead_len;
                st_o.phase   = 3'd1;
              end
              3'd3: begin
                st_o.acc     = 21'(byte_req_i[3:0]);
                st_o.seq_len = lead_len;
                st_o.phase   = 3'd2;
              end
              3'd4: begin
                st_o.acc     = 21'(byte_req_i[2:0]);
                st_o.seq_len = lead_len;
                st_o.phase   = 3'd3;
              end
              default: res_o = tld_pkg::emit(tld_pkg::CpRepl);
            endcase
          end
        end
        tld_pkg::MODE_UTF16LE, tld_pkg::MODE_UTF16BE: begin
          if (st_i.phase == 3'd0 || st_i.phase == 3'd2) begin
            st_o.held_byte = byte_req_i;
            st_o.phase     = st_i.phase + 3'd1;
          end else if (st_i.phase == 3'd1) begin
            if (unit >= tld_pkg::LeadLo && unit <= tld_pkg::LeadHi) begin
              st_o.first_unit = unit;
              st_o.phase      = 3'd2;
            end else begin
              st_o  = st_drop;
              res_o = tld_pkg::emit(21'(unit));
            end
          end else begin
            st_o = st_drop;
            if (st_i.first_unit < tld_pkg::LeadLo || st_i.first_unit > tld_pkg::LeadHi ||
                unit < tld_pkg::TrailLo || unit > tld_pkg::TrailHi) begin
              res_o = tld_pkg::emit(tld_pkg::CpRepl);
            end else begin
              res_o = tld_pkg::emit(pair_cp);
            end
          end
        end
        default: res_o = tld_pkg::emit(21'(byte_req_i));
      endcase
      if (res_o.valid) begin
        st_o.line_nonempty = res_o.char_valid;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/text_line_decoder.sv
// Top level of the text line decoder: state, output register and skid stage.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | kind_i, byte_req_i
//  out     | output    | out_valid_o / out_stall_i | code_point_o, char_valid_o, line_end_o
//  cfg     | input     | cfg_we_i                  | cfg_wdata_i (encoding mode)
//
// One byte is accepted every cycle while in_stall_o is low; its result goes to the
// output register, or to the skid register while the output is stalled. The decode
// is a single pass of logic in tld_decode. A skid register takes one result while
// the output is stalled; in_stall_o rises only while that skid register is full.
// Reset clears the mode to Latin-1, the decoder state and both valid flags.
`default_nettype none
`include "assert_macros.svh"

module text_line_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  byte_req_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [20:0]      code_point_o,
  output logic             char_valid_o,
  output logic             line_end_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_wdata_i
);

  tld_pkg::mode_e  mode_q;
  tld_pkg::state_t st_q, st_d;
  tld_pkg::res_t   res;
  tld_pkg::res_t   out_q, skid_q;
  logic            out_valid_q, skid_valid_q;
  logic            accept, push, out_free;

  tld_decode u_decode (
    .mode_i    (mode_q),
    .st_i      (st_q),
    .kind_i    (kind_i),
    .byte_req_i(byte_req_i),
    .st_o      (st_d),
    .res_o     (res)
  );

  assign accept   = in_valid_i && !skid_valid_q;
  assign push     = accept && res.valid;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tld_pkg::MODE_LATIN1;
      st_q   <= '0;
    end else if (cfg_we_i) begin
      // Drop any partial sequence, keep the line state.
      mode_q <= tld_pkg::mode_e'(cfg_wdata_i);
      st_q   <= '{phase: 3'd0, acc: '0, seq_len: 3'd0, first_unit: '0,
                  held_byte: '0, line_nonempty: st_q.line_nonempty};
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign in_stall_o   = skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign code_point_o = out_q.code_point;
  assign char_valid_o = out_q.char_valid;
  assign line_end_o   = out_q.line_end;

  `TLD_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full with output empty")
  `TLD_ASSERT(a_one_kind, out_valid_o |-> (char_valid_o != line_end_o), "result kind not exclusive")
  `TLD_ASSERT(a_no_surrogate, out_valid_o && char_valid_o |-> code_point_o[20:11] != 10'h01B, "surrogate delivered")
  `TLD_ASSERT(a_line_end_zero, out_valid_o && line_end_o |-> code_point_o == 21'd0, "line end carries a code point")

endmodule

`default_nettype wire

// File: bench/text_line_decoder_tb.sv
// Self-checking testbench for the text line decoder: directed and random byte streams.
`default_nettype none

module text_line_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KindData = 1'b0;
  localparam logic KindEos  = 1'b1;

  localparam logic [7:0] ByteNewline = 8'h0A;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainLimit = 20000;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned ItemsPerSegment = 130;

  typedef struct {
    logic       kind;
    logic [7:0] data;
  } byte_item_t;

  typedef struct {
    logic [tld_pkg::CpW-1:0] code_point;
    logic                    char_valid;
    logic                    line_end;
  } char_result_t;

  logic                    clk_i;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    kind_i = 1'b0;
  logic [7:0]              byte_req_i = 8'h00;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [tld_pkg::CpW-1:0] code_point_o;
  logic                    char_valid_o;
  logic                    line_end_o;
  logic                    cfg_we_i = 1'b0;
  logic [1:0]              cfg_wdata_i = 2'd0;

  byte_item_t   pending_bytes[$];
  char_result_t expected_chars[$];

  int unsigned tx_idle_pct = 9;
  int unsigned rx_idle_pct = 67;
  bit          pressure_on = 1'b0;
  int unsigned holdoff_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Decoder shadow state
  tld_pkg::mode_e          cur_mode = tld_pkg::MODE_LATIN1;
  logic [2:0]              dec_phase = '0;
  logic [tld_pkg::CpW-1:0] cp_acc = '0;
  logic [2:0]              seq_total = '0;
  logic [15:0]             lead_unit = '0;
  logic [7:0]              half_byte = '0;
  logic                    line_open = 1'b0;

  text_line_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .byte_req_i  (byte_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_point_o(code_point_o),
    .char_valid_o(char_valid_o),
    .line_end_o  (line_end_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [tld_pkg::CpW-1:0] scrub_cp(input logic [tld_pkg::CpW-1:0] cp);
    if (cp >= 21'h00D800 && cp <= 21'h00DFFF) begin
      return tld_pkg::CpRepl;
    end
    if (cp == 21'h00FFFE || cp == 21'h00FFFF || cp == 21'h00FEFF) begin
      return tld_pkg::CpRepl;
    end
    return cp;
  endfunction

  task automatic clear_partial();
    dec_phase = '0;
    cp_acc    = '0;
    seq_total = '0;
    lead_unit = '0;
    half_byte = '0;
  endtask

  // A newline closes the line instead of producing a character.
  task automatic put_char(input logic [tld_pkg::CpW-1:0] cp);
    char_result_t c;
    if (cp == tld_pkg::CpNewline) begin
      c.code_point = '0;
      c.char_valid = 1'b0;
      c.line_end   = 1'b1;
      line_open    = 1'b0;
    end else begin
      c.code_point = scrub_cp(cp);
      c.char_valid = 1'b1;
      c.line_end   = 1'b0;
      line_open    = 1'b1;
    end
    expected_chars.push_back(c);
  endtask

  task automatic decode_byte(input logic kind, input logic [7:0] b);
    char_result_t            c;
    logic [15:0]             unit16;
    logic [15:0]             lead;
    logic [tld_pkg::CpW-1:0] cp;
    logic [tld_pkg::CpW-1:0] floor_cp;
    logic [tld_pkg::CpW-1:0] hi;
    logic [tld_pkg::CpW-1:0] lo;
    int                      ones;
    if (kind == KindEos) begin
      clear_partial();
      if (line_open) begin
        line_open    = 1'b0;
        c.code_point = '0;
        c.char_valid = 1'b0;
        c.line_end   = 1'b1;
        expected_chars.push_back(c);
      end
      return;
    end
    case (cur_mode)
      tld_pkg::MODE_LATIN1: begin
        put_char({13'd0, b});
      end
      tld_pkg::MODE_UTF8: begin
        if (dec_phase != 0) begin
          if (b[7:6] != 2'b10) begin
            clear_partial();
            put_char(tld_pkg::CpRepl);
          end else begin
            cp_acc    = {cp_acc[14:0], b[5:0]};
            dec_phase = dec_phase - 3'd1;
            if (dec_phase == 0) begin
              cp = cp_acc;
              case (seq_total)
                3'd2:    floor_cp = 21'h000080;
                3'd3:    floor_cp = 21'h000800;
                3'd4:    floor_cp = 21'h010000;
                default: floor_cp = 21'h000000;
              endcase
              clear_partial();
              put_char((cp < floor_cp) ? tld_pkg::CpRepl : cp);
            end
          end
        end else begin
          ones = 0;
          while (ones < 7 && b[7-ones]) begin
            ones++;
          end
          if (ones == 0) begin
            put_char({13'd0, b});
          end else if (ones == 1 || ones > 4) begin
            put_char(tld_pkg::CpRepl);
          end else begin
            cp_acc    = {13'd0, b & (8'h7F >> ones)};
            seq_total = 3'(ones);
            dec_phase = 3'(ones - 1);
          end
        end
      end
      default: begin
        if (dec_phase == 0 || dec_phase == 2) begin
          half_byte = b;
          dec_phase = dec_phase + 3'd1;
        end else begin
          unit16 = (cur_mode == tld_pkg::MODE_UTF16LE) ? {b, half_byte} : {half_byte, b};
          if (dec_phase == 1) begin
            if (unit16 >= tld_pkg::LeadLo && unit16 <= tld_pkg::LeadHi) begin
              lead_unit = unit16;
              dec_phase = 3'd2;
            end else begin
              clear_partial();
              put_char({5'd0, unit16});
            end
          end else begin
            lead = lead_unit;
            clear_partial();
            if (unit16 < tld_pkg::TrailLo || unit16 > tld_pkg::TrailHi) begin
              put_char(tld_pkg::CpRepl);
            end else begin
              hi = {5'd0, lead - tld_pkg::LeadLo};
              lo = {5'd0, unit16 - tld_pkg::TrailLo};
              put_char(((hi << 10) | lo) + tld_pkg::CpSurrBase);
            end
          end
        end
      end
    endcase
  endtask

  // Sender: present queued bytes, hold a stalled transaction.
  always @(posedge clk_i) begin : drive_bytes
    byte_item_t next_item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(kind_i, byte_req_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          next_item  = pending_bytes.pop_front();
          in_valid_i <= 1'b1;
          kind_i     <= next_item.kind;
          byte_req_i <= next_item.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transaction against the oldest expected character.
  always @(posedge clk_i) begin : watch_chars
    char_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected transaction: code_point %h char_valid %b line_end %b",
               code_point_o, char_valid_o, line_end_o);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (code_point_o !== want.code_point) begin
          $error("code_point: expected %h, got %h", want.code_point, code_point_o);
          fail_count++;
        end
        if (char_valid_o !== want.char_valid) begin
          $error("char_valid: expected %b, got %b", want.char_valid, char_valid_o);
          fail_count++;
        end
        if (line_end_o !== want.line_end) begin
          $error("line_end: expected %b, got %b", want.line_end, line_end_o);
          fail_count++;
        end
      end
    end
    if (pressure_on && holdoff_cycles < HoldOffCycles) begin
      holdoff_cycles <= holdoff_cycles + 1;
      out_stall_i    <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("text_line_decoder test failed");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back('{kind: KindData, data: b});
  endtask

  task automatic push_eos();
    pending_bytes.push_back('{kind: KindEos, data: 8'($urandom_range(0, 255))});
  endtask

  task automatic put_utf8(input logic [tld_pkg::CpW-1:0] cp, input int len);
    case (len)
      1: push_byte(cp[7:0]);
      2: begin
        push_byte({3'b110, cp[10:6]});
        push_byte({2'b10, cp[5:0]});
      end
      3: begin
        push_byte({4'b1110, cp[15:12]});
        push_byte({2'b10, cp[11:6]});
        push_byte({2'b10, cp[5:0]});
      end
      default: begin
        push_byte({5'b11110, cp[20:18]});
        push_byte({2'b10, cp[17:12]});
        push_byte({2'b10, cp[11:6]});
        push_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic put_unit(input logic [15:0] u);
    if (cur_mode == tld_pkg::MODE_UTF16LE) begin
      push_byte(u[7:0]);
      push_byte(u[15:8]);
    end else begin
      push_byte(u[15:8]);
      push_byte(u[7:0]);
    end
  endtask

  task automatic fill_latin1(input int unsigned count);
    int unsigned r;
    while (pending_bytes.size() < count) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_byte(ByteNewline);
      end else if (r < 11) begin
        push_eos();
      end else begin
        push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic fill_utf8(input int unsigned count);
    int unsigned             r;
    int                      len;
    int                      conts;
    logic [tld_pkg::CpW-1:0] cp;
    logic [7:0]              b;
    while (pending_bytes.size() < count) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_byte(ByteNewline);
      end else if (r < 10) begin
        push_eos();
      end else if (r < 35) begin
        put_utf8(21'($urandom_range(0, 8'h7F)), 1);
      end else if (r < 50) begin
        put_utf8(21'($urandom_range(12'h080, 12'h7FF)), 2);
      end else if (r < 65) begin
        put_utf8(21'($urandom_range(16'h0800, 16'hFFFF)), 3);
      end else if (r < 78) begin
        // the upper part runs past U+10FFFF on purpose
        put_utf8(21'($urandom_range(21'h010000, 21'h1FFFFF)), 4);
      end else if (r < 83) begin
        len = $urandom_range(2, 4);
        case (len)
          2:       cp = 21'($urandom_range(0, 12'h07F));
          3:       cp = 21'($urandom_range(0, 12'h7FF));
          default: cp = 21'($urandom_range(0, 16'hFFFF));
        endcase
        put_utf8(cp, len);
      end else if (r < 88) begin
        // cut a sequence short, then break it or end the stream
        len   = $urandom_range(2, 4);
        conts = $urandom_range(0, len - 2);
        cp    = 21'($urandom_range(0, 21'h1FFFFF));
        case (len)
          2:       push_byte({3'b110, cp[4:0]});
          3:       push_byte({4'b1110, cp[3:0]});
          default: push_byte({5'b11110, cp[2:0]});
        endcase
        repeat (conts) push_byte({2'b10, 6'($urandom_range(0, 63))});
        if ($urandom_range(0, 1) == 0) begin
          push_eos();
        end else begin
          b = 8'($urandom_range(0, 255));
          if (b[7:6] == 2'b10) begin
            b = b ^ 8'h40;
          end
          push_byte(b);
        end
      end else if (r < 94) begin
        push_byte(8'($urandom_range(0, 255)));
      end else if (r < 97) begin
        push_byte(8'($urandom_range(8'hF8, 8'hFF)));
      end else begin
        push_byte(8'($urandom_range(8'h80, 8'hBF)));
      end
    end
  endtask

  task automatic fill_utf16(input int unsigned count);
    int unsigned r;
    logic [15:0] u;
    logic [19:0] v;
    while (pending_bytes.size() < count) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        put_unit(16'h000A);
      end else if (r < 10) begin
        push_eos();
      end else if (r < 45) begin
        u = 16'($urandom_range(0, 16'hFFFF));
        if (u >= tld_pkg::LeadLo && u <= tld_pkg::TrailHi) begin
          u = u ^ 16'h4000;
        end
        put_unit(u);
      end else if (r < 70) begin
        v = 20'($urandom_range(21'h010000, 21'h10FFFF) - 21'h010000);
        put_unit(tld_pkg::LeadLo | {6'd0, v[19:10]});
        put_unit(tld_pkg::TrailLo | {6'd0, v[9:0]});
      end else if (r < 78) begin
        put_unit(16'($urandom_range(tld_pkg::LeadLo, tld_pkg::LeadHi)));
        u = 16'($urandom_range(0, 16'hFFFF));
        if (u >= tld_pkg::TrailLo && u <= tld_pkg::TrailHi) begin
          u = u ^ 16'h2000;
        end
        put_unit(u);
      end else if (r < 84) begin
        put_unit(16'($urandom_range(tld_pkg::TrailLo, tld_pkg::TrailHi)));
      end else if (r < 88) begin
        case ($urandom_range(0, 2))
          0:       put_unit(16'hFFFE);
          1:       put_unit(16'hFFFF);
          default: put_unit(16'hFEFF);
        endcase
      end else if (r < 94) begin
        // a stray byte shifts the unit alignment
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        push_byte(8'($urandom_range(0, 255)));
        push_eos();
      end
    end
  endtask

  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    while ((pending_bytes.size() != 0 || in_valid_i || expected_chars.size() != 0)
           && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    // a held partial sequence makes no transaction, so allow the pipeline to settle
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_mode(input tld_pkg::mode_e m);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    cur_mode = m;
    clear_partial();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin : run_stimulus
    tld_pkg::mode_e seg_modes [12];
    int             seg;
    seg_modes = '{tld_pkg::MODE_LATIN1, tld_pkg::MODE_UTF8, tld_pkg::MODE_UTF16LE,
                  tld_pkg::MODE_UTF16BE, tld_pkg::MODE_UTF16BE, tld_pkg::MODE_UTF16LE,
                  tld_pkg::MODE_UTF8, tld_pkg::MODE_LATIN1, tld_pkg::MODE_UTF8,
                  tld_pkg::MODE_UTF16LE, tld_pkg::MODE_LATIN1, tld_pkg::MODE_UTF16BE};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Latin-1 after reset: newline on an empty line, byte extremes, stream ends
    push_byte(ByteNewline);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_eos();
    push_eos();
    wait_idle();

    // UTF-8: bad leads, overlong, broken continuation, above U+10FFFF, FFFE
    set_mode(tld_pkg::MODE_UTF8);
    push_byte(8'h80);
    push_byte(8'hF8);
    push_byte(8'hC0);
    push_byte(8'h80);
    push_byte(8'hE2);
    push_byte(8'h41);
    put_utf8(21'h1FFFFF, 4);
    put_utf8(21'h00FFFE, 3);
    // leave a partial sequence for the mode change to drop
    push_byte(8'hE2);
    wait_idle();

    // UTF-16LE: surrogate pair, lead without trail, byte order mark
    set_mode(tld_pkg::MODE_UTF16LE);
    put_unit(16'hD83D);
    put_unit(16'hDE00);
    put_unit(16'hD800);
    put_unit(16'h0041);
    put_unit(16'hFEFF);
    wait_idle();

    for (seg = 0; seg < 12; seg++) begin
      if (seg < 4) begin
        tx_idle_pct = 9;
        rx_idle_pct = 67;
      end else if (seg < 8) begin
        tx_idle_pct = 67;
        rx_idle_pct = 9;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_mode(seg_modes[seg]);
      if (seg == 8) begin
        pressure_on = 1'b1;
      end
      case (seg_modes[seg])
        tld_pkg::MODE_LATIN1: fill_latin1(ItemsPerSegment);
        tld_pkg::MODE_UTF8:   fill_utf8(ItemsPerSegment);
        default:              fill_utf16(ItemsPerSegment);
      endcase
      wait_idle();
    end

    if (expected_chars.size() != 0) begin
      $error("%0d expected characters never arrived", expected_chars.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("text_line_decoder test passed");
    end else begin
      $display("text_line_decoder test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: text_line_decoder.f
+incdir+design
design/tld_pkg.sv
design/tld_decode.sv
design/text_line_decoder.sv
bench/text_line_decoder_tb.sv
